// ===== sv/unstuff_decode_trade_accumulate_defines.svh =====
// Assertion macros used by the checker file of the order decoder.
`ifndef UNSTUFF_DECODE_TRADE_ACCUMULATE_DEFINES_SVH
`define UNSTUFF_DECODE_TRADE_ACCUMULATE_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define UDTA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also covers the reset cycles.
`define UDTA_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/udta_pkg.sv =====
// Shared constants and types of the order destuffing decoder.
package udta_pkg;

    // Destuffing geometry.
    localparam int WORD_BITS = 64;
    localparam int OUT_BITS  = 49;
    localparam int RUN_LIMIT = 5;
    localparam int RUN_W     = 3;
    // Output bits settled per front stage; the stage count follows from it.
    localparam int STEPS     = 7;
    localparam int STAGES    = OUT_BITS / STEPS;

    // Field layout of the destuffed order.
    localparam int ID_W      = 32;
    localparam int SELL_BIT  = 32;
    localparam int QTY_LSB   = 33;
    localparam int PRC_LSB   = 41;
    localparam int FIELD_W   = 8;
    localparam int AMT_W     = 16;
    localparam int TOTAL_W   = 48;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One destuffed order waiting for the back end.
    typedef struct packed {
        logic [OUT_BITS-1:0] bits;
        logic                last;
    } t_item;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/udta_front.sv =====
// Front end: pipelined bit destuffing of the incoming order words.
module udta_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [udta_pkg::WORD_BITS-1:0] i_stuffed_word,
    input  logic                           i_end_of_batch,
    input  udta_pkg::t_q_stat              i_q_stat,
    output logic                           o_push,
    output udta_pkg::t_item                o_item
);
    import udta_pkg::*;

    logic                 w_advance;
    logic [STAGES-1:0]    r_valid;
    logic [WORD_BITS-1:0] r_word [STAGES];
    logic [RUN_W-1:0]     r_run  [STAGES];
    logic [OUT_BITS-1:0]  r_res  [STAGES];
    logic                 r_last [STAGES];
    logic [STAGES-1:0]    w_src_valid;
    logic [WORD_BITS-1:0] w_src_word [STAGES];
    logic [RUN_W-1:0]     w_src_run  [STAGES];
    logic [OUT_BITS-1:0]  w_src_res  [STAGES];
    logic                 w_src_last [STAGES];
    logic [WORD_BITS-1:0] n_word [STAGES];
    logic [RUN_W-1:0]     n_run  [STAGES];
    logic [OUT_BITS-1:0]  n_res  [STAGES];

    // The whole pipeline moves unless the oldest word cannot enter the queue.
    assign w_advance  = !(r_valid[STAGES-1] && i_q_stat.full);
    assign o_in_stall = !w_advance;
    assign o_push     = r_valid[STAGES-1] && w_advance;
    assign o_item     = '{bits: r_res[STAGES-1], last: r_last[STAGES-1]};

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        // Stage inputs come from the port for the first stage and from the
        // previous stage otherwise.
        if (s == 0) begin : g_first
            assign w_src_valid[s] = i_in_valid;
            assign w_src_word[s]  = i_stuffed_word;
            assign w_src_run[s]   = '0;
            assign w_src_res[s]   = '0;
            assign w_src_last[s]  = i_end_of_batch;
        end else begin : g_next
            assign w_src_valid[s] = r_valid[s-1];
            assign w_src_word[s]  = r_word[s-1];
            assign w_src_run[s]   = r_run[s-1];
            assign w_src_res[s]   = r_res[s-1];
            assign w_src_last[s]  = r_last[s-1];
        end

        // Settle this stage's output bits. The remaining word is shifted so
        // that the next bit to scan sits at bit 0; zeros shift in, so bits
        // past the end of the word read as zero.
        always_comb begin
            logic [WORD_BITS-1:0] v_word;
            logic [RUN_W-1:0]     v_run;
            logic [OUT_BITS-1:0]  v_res;
            v_word = w_src_word[s];
            v_run  = w_src_run[s];
            v_res  = w_src_res[s];
            for (int k = 0; k < STEPS; k++) begin
                v_res[s*STEPS + k] = v_word[0];
                if (v_word[0]) begin
                    if (v_run == RUN_W'(RUN_LIMIT - 1)) begin
                        // Fifth one in a row: the stuffed bit is dropped.
                        v_run  = '0;
                        v_word = v_word >> 2;
                    end else begin
                        v_run  = v_run + 1'b1;
                        v_word = v_word >> 1;
                    end
                end else begin
                    v_run  = '0;
                    v_word = v_word >> 1;
                end
            end
            n_word[s] = v_word;
            n_run[s]  = v_run;
            n_res[s]  = v_res;
        end

        // Stage valid flag.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_advance) begin
                r_valid[s] <= w_src_valid[s];
            end
        end

        // Stage payload.
        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_word[s] <= n_word[s];
                r_run[s]  <= n_run[s];
                r_res[s]  <= n_res[s];
                r_last[s] <= w_src_last[s];
            end
        end
    end

endmodule

// ===== sv/udta_queue.sv =====
// Short queue that decouples the destuffing front from the trade back end.
module udta_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  udta_pkg::t_item   i_item,
    input  logic              i_pop,
    output udta_pkg::t_item   o_head,
    output udta_pkg::t_q_stat o_q_stat
);
    import udta_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd];
    assign o_q_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q_stat.empty = (r_count == '0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== sv/udta_back.sv =====
// Back end: field decode, trade amount and saturating batch total.
module udta_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  udta_pkg::t_q_stat            i_q_stat,
    input  udta_pkg::t_item              i_head,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [udta_pkg::ID_W-1:0]    o_stock_id,
    output logic                         o_is_sell,
    output logic [udta_pkg::FIELD_W-1:0] o_quantity,
    output logic [udta_pkg::FIELD_W-1:0] o_price,
    output logic [udta_pkg::AMT_W-1:0]   o_trade_amount,
    output logic [udta_pkg::TOTAL_W-1:0] o_running_total,
    output logic                         o_batch_done
);
    import udta_pkg::*;

    logic                 w_advance;
    logic [TOTAL_W:0]     w_sum;
    logic [TOTAL_W-1:0]   w_sat;
    logic                 r_b_valid;
    logic [ID_W-1:0]      r_b_id;
    logic                 r_b_sell;
    logic [FIELD_W-1:0]   r_b_qty;
    logic [FIELD_W-1:0]   r_b_prc;
    logic [AMT_W-1:0]     r_b_amt;
    logic                 r_b_last;
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    logic                 r_out_sell;
    logic [FIELD_W-1:0]   r_out_qty;
    logic [FIELD_W-1:0]   r_out_prc;
    logic [AMT_W-1:0]     r_out_amt;
    logic [TOTAL_W-1:0]   r_out_total;
    logic                 r_out_last;
    logic [TOTAL_W-1:0]   r_total;

    // Both back stages move together unless a result waits on a stall.
    assign w_advance = !(r_out_valid && i_out_stall);
    assign o_pop     = w_advance && !i_q_stat.empty;

    // Add this trade to the batch total and clamp at the 48-bit maximum.
    assign w_sum = {1'b0, r_total} + {{(TOTAL_W + 1 - AMT_W){1'b0}}, r_b_amt};
    assign w_sat = w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];

    // Decode and multiply stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_advance) begin
            r_b_valid <= !i_q_stat.empty;
        end
    end

    // Decode and multiply stage payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_id   <= i_head.bits[ID_W-1:0];
            r_b_sell <= i_head.bits[SELL_BIT];
            r_b_qty  <= i_head.bits[QTY_LSB +: FIELD_W];
            r_b_prc  <= i_head.bits[PRC_LSB +: FIELD_W];
            r_b_amt  <= i_head.bits[QTY_LSB +: FIELD_W] * i_head.bits[PRC_LSB +: FIELD_W];
            r_b_last <= i_head.last;
        end
    end

    // Output valid and the running total, which clears after a closing order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_b_valid;
            if (r_b_valid) begin
                r_total <= r_b_last ? '0 : w_sat;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_advance && r_b_valid) begin
            r_out_id    <= r_b_id;
            r_out_sell  <= r_b_sell;
            r_out_qty   <= r_b_qty;
            r_out_prc   <= r_b_prc;
            r_out_amt   <= r_b_amt;
            r_out_total <= w_sat;
            r_out_last  <= r_b_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stock_id      = r_out_id;
    assign o_is_sell       = r_out_sell;
    assign o_quantity      = r_out_qty;
    assign o_price         = r_out_prc;
    assign o_trade_amount  = r_out_amt;
    assign o_running_total = r_out_total;
    assign o_batch_done    = r_out_last;

endmodule

// ===== sv/unstuff_decode_trade_accumulate.sv =====
// Top level of the destuffing order decoder with batch trade accumulation.
//
//   Channel   Handshake                 Payload
//   in        i_in_valid / o_in_stall   i_stuffed_word, i_end_of_batch
//   out       o_out_valid / i_out_stall o_stock_id, o_is_sell, o_quantity, o_price,
//                                       o_trade_amount, o_running_total, o_batch_done
//
// One order word is taken every cycle while o_in_stall is low. Each result
// passes the seven destuffing stages (seven output bits each), the queue
// memory, the multiply stage and the output register, in that order.
// Reset is synchronous and clears all valid flags, the queue
// and the running total. An output stall holds the back end and lets the queue
// fill; the front stalls its input only when the queue is full.
module unstuff_decode_trade_accumulate (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [udta_pkg::WORD_BITS-1:0] i_stuffed_word,
    input  logic                         i_end_of_batch,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [udta_pkg::ID_W-1:0]    o_stock_id,
    output logic                         o_is_sell,
    output logic [udta_pkg::FIELD_W-1:0] o_quantity,
    output logic [udta_pkg::FIELD_W-1:0] o_price,
    output logic [udta_pkg::AMT_W-1:0]   o_trade_amount,
    output logic [udta_pkg::TOTAL_W-1:0] o_running_total,
    output logic                         o_batch_done
);
    import udta_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_item   w_item;
    t_item   w_head;
    t_q_stat w_q_stat;

    // Destuffing pipeline.
    udta_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_stuffed_word (i_stuffed_word),
        .i_end_of_batch (i_end_of_batch),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_item         (w_item)
    );

    // Decoupling queue.
    udta_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_q_stat (w_q_stat)
    );

    // Decode, multiply and accumulate.
    udta_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (w_q_stat),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_stock_id      (o_stock_id),
        .o_is_sell       (o_is_sell),
        .o_quantity      (o_quantity),
        .o_price         (o_price),
        .o_trade_amount  (o_trade_amount),
        .o_running_total (o_running_total),
        .o_batch_done    (o_batch_done)
    );

endmodule

// ===== sv/udta_checker.sv =====
// Port-level checks of the order decoder and their binding to the top level.
`include "unstuff_decode_trade_accumulate_defines.svh"

module udta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [udta_pkg::WORD_BITS-1:0] i_stuffed_word,
    input logic                         i_end_of_batch,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [udta_pkg::ID_W-1:0]    o_stock_id,
    input logic                         o_is_sell,
    input logic [udta_pkg::FIELD_W-1:0] o_quantity,
    input logic [udta_pkg::FIELD_W-1:0] o_price,
    input logic [udta_pkg::AMT_W-1:0]   o_trade_amount,
    input logic [udta_pkg::TOTAL_W-1:0] o_running_total,
    input logic                         o_batch_done
);
    import udta_pkg::*;

    logic [WORD_BITS:0]                        w_in_payload;
    logic [ID_W+1+2*FIELD_W+AMT_W+TOTAL_W:0]   w_out_payload;

    // Whole payloads of both channels, for the hold checks.
    assign w_in_payload  = {i_stuffed_word, i_end_of_batch};
    assign w_out_payload = {o_stock_id, o_is_sell, o_quantity, o_price,
                            o_trade_amount, o_running_total, o_batch_done};

    // No result may be shown in the cycle after reset.
    `UDTA_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A stalled input transfer keeps its valid flag and its payload.
    `UDTA_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(w_in_payload), "stalled input changed")

    // A stalled result keeps its valid flag and its payload.
    `UDTA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(w_out_payload), "stalled result changed")

    // The trade amount is the product of the decoded quantity and price.
    `UDTA_ASSERT(a_amount, i_clk, i_rst_n, o_out_valid |-> o_trade_amount == AMT_W'(o_quantity) * AMT_W'(o_price), "trade amount mismatch")

    // The batch total always includes the current trade.
    `UDTA_ASSERT(a_total_floor, i_clk, i_rst_n, o_out_valid |-> o_running_total >= TOTAL_W'(o_trade_amount), "total below trade amount")

endmodule

bind unstuff_decode_trade_accumulate udta_checker u_udta_checker (.*);
